@@ sv/sha1_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-1 hasher package
// Shared types and constants for the SHA-1 byte stream hasher.
// ----------------------------------------------------------------------------
package sha1_pkg;

  typedef enum logic [1:0] {
    FUNC_ABSORB     = 2'd0,
    FUNC_ABSORB_FIN = 2'd1,
    FUNC_FINISH     = 2'd2,
    FUNC_NONE       = 2'd3
  } func_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
  } in_req_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;
    logic        error;
  } out_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_PAD,
    ST_LEN_HI,
    ST_LEN_LO,
    ST_CMP_LOAD,
    ST_CMP_RUN,
    ST_CMP_ADD,
    ST_CMP_CLR,
    ST_EMIT_RD,
    ST_EMIT,
    ST_ERR,
    ST_INIT
  } state_t;

  localparam logic [31:0] IV [5] = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                     32'h10325476, 32'hC3D2E1F0};
  localparam logic [31:0] KC [4] = '{32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC,
                                     32'hCA62C1D6};
  localparam int unsigned PAD_LIMIT_BYTES = 55;

  typedef struct packed {
    logic [6:0] round;
  } rnd_ctl_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

endpackage

@@ sv/sha1_round.sv @@
// ----------------------------------------------------------------------------
// SHA-1 round unit
// One compression round per cycle while step is high, with a 16-word rolling schedule window.
// ----------------------------------------------------------------------------
module sha1_round (
  input  logic                 clk,
  input  logic                 load,
  input  logic                 step,
  input  sha1_pkg::rnd_ctl_t   ctl,
  input  logic [31:0]          load_w,
  input  logic [3:0]           load_idx,
  input  logic [159:0]         init_abcde,
  output logic [159:0]         abcde
);
  import sha1_pkg::*;

  logic [31:0] w_r [16];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] f, t, wi, wn;
  logic [1:0]  ph;

  always_comb begin
    if (ctl.round < 7'd20) ph = 2'd0;
    else if (ctl.round < 7'd40) ph = 2'd1;
    else if (ctl.round < 7'd60) ph = 2'd2;
    else ph = 2'd3;
    unique case (ph)
      2'd0:    f = (b_r & c_r) | (~b_r & d_r);
      2'd2:    f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      default: f = b_r ^ c_r ^ d_r;
    endcase
    wi = w_r[0];
    wn = rotl(w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0], 1);
    t  = rotl(a_r, 5) + f + e_r + wi + KC[ph];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      w_r[load_idx] <= load_w;
      {a_r, b_r, c_r, d_r, e_r} <= init_abcde;
    end else if (step) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wn;
      e_r <= d_r;
      d_r <= c_r;
      c_r <= rotl(b_r, 30);
      b_r <= a_r;
      a_r <= t;
    end
  end

  assign abcde = {a_r, b_r, c_r, d_r, e_r};
endmodule

@@ sv/sha1_byte_stream_hasher.sv @@
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher
// Absorbs message bytes into a word memory, compresses full blocks, pads and
// emits the five digest words on finish.
//
//  channel | dir | payload           | notes
//  in_     | in  | sha1_pkg::in_req_t  | func, data_byte
//  out_    | out | sha1_pkg::out_req_t | up to five per finish
//
// Absorb: word read on accept, then merge and write back.
// Full block: word load, 80 rounds, chain update and buffer clear; finish adds
// padding, length, one or two blocks, a read and an emit per result and a
// re-init. After reset an init pass clears the buffer and loads the chain; no
// request is taken meanwhile. Output stalls hold the emit sequence.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sha1_pkg::in_req_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sha1_pkg::out_req_t  out_data
);
  import sha1_pkg::*;

  // block word memory 0..15
  logic [31:0] mem [16];
  logic [31:0] rd_r;
  logic [3:0]  raddr, waddr;
  logic        we;
  logic [31:0] wdata;

  state_t      st_r, st_nxt;
  logic [5:0]  pos_r;
  logic [5:0]  pos_inc;
  logic [63:0] len_r;
  logic        long_r;
  logic        fin_r;
  logic [7:0]  byte_r;
  logic [6:0]  cnt_r;
  logic        second_r;
  logic        pad_r;
  logic        fwd_r;
  logic [31:0] hold_r;
  logic [31:0] pad_base;
  logic        emit_go;
  out_req_t    out_r;
  logic        ov_r;

  logic        rload, rstep;
  rnd_ctl_t    rctl;
  logic [159:0] abcde, chain_init;
  logic [31:0] chain_r [5];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[raddr];
  end

  assign rctl.round = cnt_r;
  assign chain_init = {chain_r[0], chain_r[1], chain_r[2], chain_r[3], chain_r[4]};
  assign pos_inc    = pos_r + 6'd1;
  assign pad_base   = (fwd_r && pos_r[1:0] != 2'd0) ? hold_r : rd_r;
  assign emit_go    = (st_r == ST_EMIT || st_r == ST_ERR) && (!ov_r || out_ready);

  sha1_round u_round (
    .clk(clk), .load(rload), .step(rstep), .ctl(rctl),
    .load_w(rd_r), .load_idx(cnt_r[3:0] - 4'd1), .init_abcde(chain_init),
    .abcde(abcde)
  );

  assign in_ready  = (st_r == ST_IDLE);
  assign out_valid = ov_r;
  assign out_data  = out_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_INIT:     if (cnt_r == 7'd15) st_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          unique case (func_t'(in_data.func))
            FUNC_ABSORB:     st_nxt = long_r ? ST_IDLE : ST_WRITE;
            FUNC_ABSORB_FIN: st_nxt = long_r ? ST_ERR : ST_WRITE;
            FUNC_FINISH:     st_nxt = long_r ? ST_ERR : ST_PAD;
            default:         st_nxt = ST_IDLE;
          endcase
        end
      end
      ST_WRITE: begin
        if (fin_r && long_r) st_nxt = ST_ERR;
        else if (pos_r == 6'd63) st_nxt = ST_CMP_LOAD;
        else if (fin_r) st_nxt = ST_PAD;
        else st_nxt = ST_IDLE;
      end
      ST_PAD: begin
        if (pos_r == 6'd63 || pos_r > 6'(PAD_LIMIT_BYTES)) st_nxt = ST_CMP_LOAD;
        else st_nxt = ST_LEN_HI;
      end
      ST_LEN_HI:   st_nxt = ST_LEN_LO;
      ST_LEN_LO:   st_nxt = ST_CMP_LOAD;
      ST_CMP_LOAD: if (cnt_r == 7'd16) st_nxt = ST_CMP_RUN;
      ST_CMP_RUN:  if (cnt_r == 7'd79) st_nxt = ST_CMP_ADD;
      ST_CMP_ADD:  st_nxt = ST_CMP_CLR;
      ST_CMP_CLR: begin
        if (cnt_r == 7'd15) begin
          if (!fin_r) st_nxt = ST_IDLE;
          else if (second_r) st_nxt = ST_EMIT_RD;
          else if (pad_r) st_nxt = ST_LEN_HI;
          else st_nxt = ST_PAD;
        end
      end
      ST_EMIT_RD:  st_nxt = ST_EMIT;
      ST_EMIT: begin
        if (emit_go) begin
          if (cnt_r == 7'd4) st_nxt = ST_INIT;
          else st_nxt = ST_EMIT_RD;
        end
      end
      ST_ERR:      if (emit_go) st_nxt = ST_INIT;
      default:     st_nxt = ST_INIT;
    endcase
  end

  always_comb begin
    raddr = 4'd0;
    we    = 1'b0;
    waddr = 4'd0;
    wdata = 32'd0;
    rload = 1'b0;
    rstep = 1'b0;
    unique case (st_r)
      ST_IDLE:     raddr = pos_r[5:2];
      ST_WRITE, ST_PAD: begin
        we    = 1'b1;
        waddr = pos_r[5:2];
        wdata = ((st_r == ST_PAD) ? pad_base : rd_r) |
                ({24'd0, (st_r == ST_PAD) ? 8'h80 : byte_r}
                 << ((2'd3 - pos_r[1:0]) * 8));
        if (st_r == ST_WRITE) raddr = pos_inc[5:2];
      end
      ST_LEN_HI: begin
        we = 1'b1; waddr = 4'd14; wdata = len_r[63:32];
      end
      ST_LEN_LO: begin
        we = 1'b1; waddr = 4'd15; wdata = len_r[31:0];
      end
      ST_CMP_LOAD: begin
        raddr = cnt_r[3:0];
        rload = (cnt_r != 7'd0);
      end
      ST_CMP_RUN:  rstep = 1'b1;
      ST_CMP_CLR, ST_INIT: begin
        we = 1'b1; waddr = cnt_r[3:0]; wdata = 32'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_INIT;
      cnt_r  <= 7'd0;
      pos_r  <= 6'd0;
      len_r  <= 64'd0;
      long_r <= 1'b0;
      fin_r  <= 1'b0;
      second_r <= 1'b0;
      pad_r  <= 1'b0;
      fwd_r  <= 1'b0;
      ov_r   <= 1'b0;
      for (int i = 0; i < 5; i++) chain_r[i] <= IV[i];
    end else begin
      st_r  <= st_nxt;
      fwd_r <= (st_r == ST_WRITE);
      if (st_r == ST_WRITE) hold_r <= wdata;
      if (emit_go) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      unique case (st_r)
        ST_INIT: begin
          cnt_r <= (cnt_r == 7'd15) ? 7'd0 : cnt_r + 7'd1;
          pos_r <= 6'd0; len_r <= 64'd0; long_r <= 1'b0;
          fin_r <= 1'b0; second_r <= 1'b0; pad_r <= 1'b0;
          for (int i = 0; i < 5; i++) chain_r[i] <= IV[i];
        end
        ST_IDLE: begin
          cnt_r <= 7'd0;
          if (in_valid) begin
            byte_r <= in_data.data_byte;
            fin_r  <= (in_data.func != FUNC_ABSORB);
            if (!long_r && (in_data.func == FUNC_ABSORB ||
                            in_data.func == FUNC_ABSORB_FIN)) begin
              len_r <= len_r + 64'd8;
              if (len_r[63:3] == '1) long_r <= 1'b1;
            end
          end
        end
        ST_WRITE: pos_r <= pos_inc;
        ST_PAD: begin
          pos_r <= pos_inc;
          pad_r <= 1'b1;
          second_r <= !(pos_r == 6'd63 || pos_r > 6'(PAD_LIMIT_BYTES));
        end
        ST_LEN_LO: second_r <= 1'b1;
        ST_CMP_LOAD: cnt_r <= (cnt_r == 7'd16) ? 7'd0 : cnt_r + 7'd1;
        ST_CMP_RUN: cnt_r <= (cnt_r == 7'd79) ? 7'd0 : cnt_r + 7'd1;
        ST_CMP_ADD: begin
          chain_r[0] <= chain_r[0] + abcde[159:128];
          chain_r[1] <= chain_r[1] + abcde[127:96];
          chain_r[2] <= chain_r[2] + abcde[95:64];
          chain_r[3] <= chain_r[3] + abcde[63:32];
          chain_r[4] <= chain_r[4] + abcde[31:0];
          pos_r <= 6'd0;
        end
        ST_CMP_CLR: cnt_r <= (cnt_r == 7'd15) ? 7'd0 : cnt_r + 7'd1;
        ST_EMIT: begin
          if (emit_go) begin
            out_r.digest_word <= chain_r[cnt_r[2:0]];
            out_r.word_index  <= cnt_r[2:0];
            out_r.last        <= (cnt_r == 7'd4);
            out_r.error       <= 1'b0;
            cnt_r <= (cnt_r == 7'd4) ? 7'd0 : cnt_r + 7'd1;
          end
        end
        ST_ERR: begin
          if (emit_go) begin
            out_r <= '{digest_word: 32'd0, word_index: 3'd0, last: 1'b1, error: 1'b1};
            cnt_r <= 7'd0;
          end
        end
        default: ;
      endcase
    end
  end

  ap_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> st_r == ST_IDLE) else $error("ready outside idle");
  ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ready |=> ov_r) else $error("result dropped");
  ap_cnt_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_CMP_RUN |-> cnt_r < 7'd80) else $error("round count overrun");
endmodule
